>>> hdl/bait_pkg.sv
// Types and constants shared by the bus activity and idle tracker.
// Depends on nothing; imported by bus_activity_idle_tracker, bait_activity_checker and tb.
`default_nettype none

package bait_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_IDLE_RST  = 2'd1,
    CMD_STATS_RST = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_BUF_EN    = 2'd2;

  localparam int unsigned RING_DEPTH_DEF = 256;

  localparam logic [15:0] INTERVAL_RST  = 16'd100;
  localparam logic [14:0] PULSE_MAX     = 15'd32767;
  localparam logic [15:0] SUM_CLAMP     = 16'd65535;
  localparam logic [31:0] MS_PER_SECOND = 32'd1000;

  // floor(n / 1000) == (n * DIV_MAGIC) >> DIV_SHIFT for every 32-bit n
  localparam logic [28:0] DIV_MAGIC = 29'd274877907;
  localparam int unsigned DIV_SHIFT = 38;

  typedef struct packed {
    cmd_t               cmd;
    logic [31:0]        now_ms;
    logic signed [15:0] pulse_raw;
    logic [7:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic        busy_res;
    logic [31:0] idle_ms;
    logic        idle_reached;
    logic [31:0] longest_idle_ms;
    logic [31:0] active_seconds;
    logic [31:0] idle_seconds;
    logic [14:0] last_pulses;
    logic [8:0]  fill_count;
    logic [7:0]  head_index;
    logic [22:0] entry_seconds;
    logic [15:0] entry_pulses;
    logic        entry_active;
  } out_item_t;

  typedef struct packed {
    logic [22:0] secs;
    logic [15:0] pulses;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/bus_activity_idle_tracker.sv
// Bus activity and idle tracker: sample folding, idle timing, per-second ring log.
// Depends on bait_pkg for the beat types, command codes and constants.
//
//   channel   handshake             payload
//   item      item_valid/item_stall bait_pkg::in_item_t
//   res       res_valid/res_stall   bait_pkg::out_item_t
//   cfg       cfg_valid/cfg_ready   cfg_index (2b), cfg_data (32b)
//
// One beat per cycle while no result is stalled; the input register takes the ring
// read and seconds multiply, then the update logic feeds the result register.
// rst is synchronous; ring contents are not cleared, fill count guards reads.
// A stalled result holds; the input register still takes one beat behind it.
// cfg_ready is low while a beat sits in the input register.
`default_nettype none

module bus_activity_idle_tracker #(
  parameter int unsigned RING_DEPTH = bait_pkg::RING_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire bait_pkg::in_item_t  item,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output bait_pkg::out_item_t      res,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import bait_pkg::*;

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);

  // configuration
  logic [15:0] sample_interval;
  logic [31:0] idle_threshold;
  logic        buffer_enable;

  // tracker state
  logic [31:0]       last_sample_time, last_sample_time_next;
  logic [31:0]       last_second_time, last_second_time_next;
  logic [14:0]       pending_pulses, pending_pulses_next;
  logic [14:0]       last_pulse_value, last_pulse_value_next;
  logic              busy_flag, busy_flag_next;
  logic [31:0]       idle_time, idle_time_next;
  logic [31:0]       longest_idle, longest_idle_next;
  logic [31:0]       second_sum, second_sum_next;
  logic [31:0]       active_count, active_count_next;
  logic [31:0]       idle_count, idle_count_next;
  logic [PTR_W-1:0]  ring_head, ring_head_next;
  logic [FILL_W-1:0] ring_fill, ring_fill_next;

  // input stage
  in_item_t    a_item;
  logic        a_valid;
  logic [22:0] a_secs;
  logic        a_adv;
  logic        item_accept;
  logic [60:0] secs_prod;

  // ring store
  entry_t           ring_mem [RING_DEPTH];
  entry_t           mem_q;
  entry_t           fwd_data;
  logic             fwd_hit;
  logic [PTR_W-1:0] rd_addr;
  entry_t           new_entry;
  logic             push;
  entry_t           rd_entry;

  // update datapath
  logic [14:0] pulses;
  logic [15:0] pend_wide;
  logic [14:0] pend_sum;
  logic [31:0] elapsed;
  logic        interval_met;
  logic [32:0] idle_wide;
  logic [31:0] idle_sat;
  logic [32:0] sec_wide;
  logic [31:0] sec_sat;
  logic [31:0] sec_elapsed;
  logic        window_done;
  logic        entry_ok;
  out_item_t   res_next;

  assign a_adv       = a_valid && (!res_valid || !res_stall);
  assign item_stall  = a_valid && !a_adv;
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = !a_valid;

  assign secs_prod = item.now_ms * DIV_MAGIC;
  assign rd_addr   = PTR_W'(item.read_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      a_item <= item;
      a_secs <= secs_prod[DIV_SHIFT +: 23];
      mem_q  <= ring_mem[rd_addr];
      // a push on this same edge is not yet visible in the read data
      fwd_hit  <= push && (ring_head == rd_addr);
      fwd_data <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring_mem[ring_head] <= new_entry;
    end
  end

  // shared arithmetic
  assign pulses       = a_item.pulse_raw[15] ? 15'd0 : a_item.pulse_raw[14:0];
  assign pend_wide    = {1'b0, pending_pulses} + {1'b0, pulses};
  assign pend_sum     = (pend_wide > {1'b0, PULSE_MAX}) ? PULSE_MAX : pend_wide[14:0];
  assign elapsed      = a_item.now_ms - last_sample_time;
  assign interval_met = elapsed >= {16'd0, sample_interval};
  assign idle_wide    = {1'b0, idle_time} + {1'b0, elapsed};
  assign idle_sat     = idle_wide[32] ? '1 : idle_wide[31:0];
  assign sec_wide     = {1'b0, second_sum} + {18'd0, pend_sum};
  assign sec_sat      = sec_wide[32] ? '1 : sec_wide[31:0];
  assign sec_elapsed  = a_item.now_ms - last_second_time;
  assign window_done  = sec_elapsed >= MS_PER_SECOND;

  assign new_entry.secs   = a_secs;
  assign new_entry.pulses = (sec_sat > {16'd0, SUM_CLAMP}) ? SUM_CLAMP : sec_sat[15:0];

  assign push = a_adv && (a_item.cmd == CMD_SAMPLE) && interval_met && window_done
                && buffer_enable;

  assign rd_entry = fwd_hit ? fwd_data : mem_q;
  assign entry_ok = (a_item.cmd == CMD_READ) && (32'(a_item.read_index) < 32'(ring_fill));

  always_comb begin
    last_sample_time_next = last_sample_time;
    last_second_time_next = last_second_time;
    pending_pulses_next   = pending_pulses;
    last_pulse_value_next = last_pulse_value;
    busy_flag_next        = busy_flag;
    idle_time_next        = idle_time;
    longest_idle_next     = longest_idle;
    second_sum_next       = second_sum;
    active_count_next     = active_count;
    idle_count_next       = idle_count;
    ring_head_next        = ring_head;
    ring_fill_next        = ring_fill;

    unique case (a_item.cmd)
      CMD_SAMPLE: begin
        if (!interval_met) begin
          pending_pulses_next = pend_sum;
        end else begin
          pending_pulses_next   = '0;
          last_sample_time_next = a_item.now_ms;
          last_pulse_value_next = pend_sum;
          busy_flag_next        = (pend_sum != '0);
          if (pend_sum != '0) begin
            idle_time_next = '0;
          end else begin
            idle_time_next = idle_sat;
            if (idle_sat > longest_idle) begin
              longest_idle_next = idle_sat;
            end
          end
          second_sum_next = sec_sat;
          if (window_done) begin
            if (buffer_enable) begin
              ring_head_next = (ring_head == PTR_W'(RING_DEPTH - 1)) ? '0 : ring_head + 1'b1;
              if (ring_fill < FILL_W'(RING_DEPTH)) begin
                ring_fill_next = ring_fill + 1'b1;
              end
            end
            if (sec_sat != '0) begin
              active_count_next = (active_count == '1) ? active_count : active_count + 1'b1;
            end else begin
              idle_count_next = (idle_count == '1) ? idle_count : idle_count + 1'b1;
            end
            second_sum_next       = '0;
            last_second_time_next = a_item.now_ms;
          end
        end
      end
      CMD_IDLE_RST: begin
        idle_time_next        = '0;
        last_sample_time_next = a_item.now_ms;
        second_sum_next       = '0;
        last_second_time_next = a_item.now_ms;
        pending_pulses_next   = '0;
      end
      CMD_STATS_RST: begin
        pending_pulses_next   = pend_sum;
        longest_idle_next     = '0;
        active_count_next     = '0;
        idle_count_next       = '0;
        ring_head_next        = '0;
        ring_fill_next        = '0;
        second_sum_next       = '0;
        last_second_time_next = a_item.now_ms;
      end
      CMD_READ: begin
        pending_pulses_next = pend_sum;
      end
      default: begin
        pending_pulses_next = pending_pulses;
      end
    endcase
  end

  always_comb begin
    res_next.busy_res        = busy_flag_next;
    res_next.idle_ms         = idle_time_next;
    res_next.idle_reached    = idle_time_next >= idle_threshold;
    res_next.longest_idle_ms = longest_idle_next;
    res_next.active_seconds  = active_count_next;
    res_next.idle_seconds    = idle_count_next;
    res_next.last_pulses     = last_pulse_value_next;
    res_next.fill_count      = 9'(ring_fill_next);
    res_next.head_index      = 8'(ring_head_next);
    res_next.entry_seconds   = entry_ok ? rd_entry.secs : '0;
    res_next.entry_pulses    = entry_ok ? rd_entry.pulses : '0;
    res_next.entry_active    = entry_ok && (rd_entry.pulses != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval  <= INTERVAL_RST;
      idle_threshold   <= '0;
      buffer_enable    <= 1'b0;
      last_sample_time <= '0;
      last_second_time <= '0;
      pending_pulses   <= '0;
      last_pulse_value <= '0;
      busy_flag        <= 1'b0;
      idle_time        <= '0;
      longest_idle     <= '0;
      second_sum       <= '0;
      active_count     <= '0;
      idle_count       <= '0;
      ring_head        <= '0;
      ring_fill        <= '0;
    end else if (a_adv) begin
      last_sample_time <= last_sample_time_next;
      last_second_time <= last_second_time_next;
      pending_pulses   <= pending_pulses_next;
      last_pulse_value <= last_pulse_value_next;
      busy_flag        <= busy_flag_next;
      idle_time        <= idle_time_next;
      longest_idle     <= longest_idle_next;
      second_sum       <= second_sum_next;
      active_count     <= active_count_next;
      idle_count       <= idle_count_next;
      ring_head        <= ring_head_next;
      ring_fill        <= ring_fill_next;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INTERVAL:  sample_interval <= cfg_data[15:0];
        REG_THRESHOLD: idle_threshold  <= cfg_data;
        REG_BUF_EN: begin
          buffer_enable <= cfg_data[0];
          ring_head     <= '0;
          ring_fill     <= '0;
        end
        default: begin
          sample_interval <= sample_interval;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FILL_W'(RING_DEPTH))
    else $error("ring fill count beyond ring depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ring_head) < RING_DEPTH)
    else $error("ring head outside the store");

  a_busy_pulses: assert property (@(posedge clk) disable iff (rst)
    busy_flag == (last_pulse_value != '0))
    else $error("busy flag disagrees with last pulse count");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (idle_time != '0) |-> !busy_flag)
    else $error("idle time running while busy");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (a_valid && res_valid && res_stall) |=> (a_valid && $stable(a_item)))
    else $error("input stage dropped a beat behind a stalled result");

endmodule

`default_nettype wire

>>> tb/bait_activity_checker.sv
// Activity checker for bus_activity_idle_tracker: predicts each status beat and compares.
// Depends on bait_pkg for the beat types, command codes, register indexes and constants.
`default_nettype none

module bait_activity_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire logic                item_stall,
  input  wire bait_pkg::in_item_t  item,
  input  wire logic                res_valid,
  input  wire logic                res_stall,
  input  wire bait_pkg::out_item_t res,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output int                       mismatch_count,
  output int                       in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import bait_pkg::*;

  // register copies
  logic [15:0] min_gap_ms;
  logic [31:0] idle_limit_ms;
  logic        log_enable;

  // tracker state
  logic [31:0] prev_sample_ms;
  logic [31:0] window_start_ms;
  logic [14:0] held_pulses;
  logic [14:0] shown_pulses;
  logic        busy;
  logic [31:0] idle_run_ms;
  logic [31:0] idle_peak_ms;
  logic [31:0] window_sum;
  logic [31:0] active_secs;
  logic [31:0] quiet_secs;
  logic [7:0]  log_head;
  logic [8:0]  log_fill;
  logic [22:0] log_secs   [RING_DEPTH_DEF];
  logic [15:0] log_pulses [RING_DEPTH_DEF];

  out_item_t expected_status[$];

  initial mismatch_count = 0;
  initial in_flight = 0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [14:0] pulse_sum(logic [14:0] a, logic [14:0] b);
    logic [15:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, PULSE_MAX}) ? PULSE_MAX : s[14:0];
  endfunction

  task automatic clear_tracker();
    min_gap_ms      = INTERVAL_RST;
    idle_limit_ms   = '0;
    log_enable      = 1'b0;
    prev_sample_ms  = '0;
    window_start_ms = '0;
    held_pulses     = '0;
    shown_pulses    = '0;
    busy            = 1'b0;
    idle_run_ms     = '0;
    idle_peak_ms    = '0;
    window_sum      = '0;
    active_secs     = '0;
    quiet_secs      = '0;
    log_head        = '0;
    log_fill        = '0;
    expected_status.delete();
  endtask

  task automatic apply_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_INTERVAL:  min_gap_ms = val[15:0];
      REG_THRESHOLD: idle_limit_ms = val;
      REG_BUF_EN: begin
        log_enable = val[0];
        log_head   = '0;
        log_fill   = '0;
      end
      default: ;
    endcase
  endtask

  // close the one-second window: log it if enabled, then count it
  task automatic close_window(logic [31:0] now);
    logic [31:0] secs;
    secs = now / MS_PER_SECOND;
    if (log_enable) begin
      log_secs[log_head]   = secs[22:0];
      log_pulses[log_head] = (window_sum > {16'd0, SUM_CLAMP}) ? SUM_CLAMP : window_sum[15:0];
      log_head = log_head + 8'd1;
      if (log_fill < 9'(RING_DEPTH_DEF))
        log_fill = log_fill + 9'd1;
    end
    if (window_sum != 0)
      active_secs = add_sat(active_secs, 32'd1);
    else
      quiet_secs = add_sat(quiet_secs, 32'd1);
    window_sum      = '0;
    window_start_ms = now;
  endtask

  task automatic predict_status(in_item_t it);
    out_item_t   st;
    logic [14:0] pulses;
    logic [14:0] count;
    logic [31:0] elapsed;
    st = '0;
    pulses = it.pulse_raw[15] ? 15'd0 : it.pulse_raw[14:0];
    case (it.cmd)
      CMD_SAMPLE: begin
        elapsed = it.now_ms - prev_sample_ms;
        if (elapsed < {16'd0, min_gap_ms}) begin
          held_pulses = pulse_sum(held_pulses, pulses);
        end else begin
          count          = pulse_sum(held_pulses, pulses);
          held_pulses    = '0;
          prev_sample_ms = it.now_ms;
          shown_pulses   = count;
          busy           = (count != 0);
          if (busy) begin
            idle_run_ms = '0;
          end else begin
            idle_run_ms = add_sat(idle_run_ms, elapsed);
            if (idle_run_ms > idle_peak_ms)
              idle_peak_ms = idle_run_ms;
          end
          window_sum = add_sat(window_sum, {17'd0, count});
          if (it.now_ms - window_start_ms >= MS_PER_SECOND)
            close_window(it.now_ms);
        end
      end
      CMD_IDLE_RST: begin
        // edges of this beat are dropped along with the pending count
        idle_run_ms     = '0;
        prev_sample_ms  = it.now_ms;
        window_sum      = '0;
        window_start_ms = it.now_ms;
        held_pulses     = '0;
      end
      CMD_STATS_RST: begin
        held_pulses     = pulse_sum(held_pulses, pulses);
        idle_peak_ms    = '0;
        active_secs     = '0;
        quiet_secs      = '0;
        log_head        = '0;
        log_fill        = '0;
        window_sum      = '0;
        window_start_ms = it.now_ms;
      end
      default: begin
        held_pulses = pulse_sum(held_pulses, pulses);
        if ({1'b0, it.read_index} < log_fill) begin
          st.entry_seconds = log_secs[it.read_index];
          st.entry_pulses  = log_pulses[it.read_index];
          st.entry_active  = (log_pulses[it.read_index] != 0);
        end
      end
    endcase
    st.busy_res        = busy;
    st.idle_ms         = idle_run_ms;
    st.idle_reached    = (idle_run_ms >= idle_limit_ms);
    st.longest_idle_ms = idle_peak_ms;
    st.active_seconds  = active_secs;
    st.idle_seconds    = quiet_secs;
    st.last_pulses     = shown_pulses;
    st.fill_count      = log_fill;
    st.head_index      = log_head;
    expected_status.push_back(st);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_status(out_item_t got);
    out_item_t want;
    if (expected_status.size() == 0) begin
      $display("%0t ns: status beat with nothing expected, got %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_status.pop_front();
    check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    check_field("idle_ms", want.idle_ms, got.idle_ms);
    check_field("idle_reached", 32'(want.idle_reached), 32'(got.idle_reached));
    check_field("longest_idle_ms", want.longest_idle_ms, got.longest_idle_ms);
    check_field("active_seconds", want.active_seconds, got.active_seconds);
    check_field("idle_seconds", want.idle_seconds, got.idle_seconds);
    check_field("last_pulses", 32'(want.last_pulses), 32'(got.last_pulses));
    check_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
    check_field("head_index", 32'(want.head_index), 32'(got.head_index));
    check_field("entry_seconds", 32'(want.entry_seconds), 32'(got.entry_seconds));
    check_field("entry_pulses", 32'(want.entry_pulses), 32'(got.entry_pulses));
    check_field("entry_active", 32'(want.entry_active), 32'(got.entry_active));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tracker();
      in_flight <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      if (res_valid && !res_stall)
        compare_status(res);
      if (item_valid && !item_stall)
        predict_status(item);
      in_flight <= in_flight + int'(item_valid && !item_stall) - int'(res_valid && !res_stall);
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench top for bus_activity_idle_tracker: clock, reset, stimulus phases and verdict.
// Depends on bait_pkg and on bait_activity_checker, which predicts and compares.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bait_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // not a register, must be ignored
  localparam int         LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  out_item_t   res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int mismatch_count;
  int in_flight;

  logic [31:0] clock_ms = '0;
  logic [15:0] interval_cfg = INTERVAL_RST;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_served = 1'b0;
  int          hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bus_activity_idle_tracker u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bait_activity_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res            (res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .in_flight      (in_flight)
  );

  // status receiver: one long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      res_stall   <= 1'b1;
      hold_left   <= LONG_HOLD;
      hold_served <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  task automatic send_beat(cmd_t c, logic [31:0] t, logic [15:0] p, logic [7:0] idx);
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid      <= 1'b1;
    item.cmd        <= c;
    item.now_ms     <= t;
    item.pulse_raw  <= p;
    item.read_index <= idx;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic put(cmd_t c, logic [31:0] t, logic [15:0] p, logic [7:0] idx);
    clock_ms = t;
    send_beat(c, t, p, idx);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [15:0] intv, logic [31:0] thr, logic en);
    write_reg(REG_INTERVAL, {16'($urandom_range(0, 65535)), intv});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_BUF_EN, {31'($urandom), en});
    cfg_valid    <= 1'b0;
    interval_cfg  = intv;
  endtask

  // wait until every status beat has come back, then let the pipeline empty
  task automatic settle();
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pulses();
    int r;
    r = $urandom_range(1, 100);
    if (r <= 45) return 16'd0;
    if (r <= 75) return 16'($urandom_range(1, 50));
    if (r <= 85) return 16'($urandom_range(32768, 65535));
    if (r <= 95) return 16'($urandom);
    return 16'h7FFF;
  endfunction

  task automatic random_beats(int n, int sample_pct, int long_pct, bit allow_stats);
    int          r;
    logic [31:0] step;
    cmd_t        c;
    logic [7:0]  idx;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(1, 100);
      if (r <= sample_pct) begin
        c = CMD_SAMPLE;
      end else begin
        case ($urandom_range(0, 3))
          0: c = CMD_IDLE_RST;
          1: c = allow_stats ? CMD_STATS_RST : CMD_READ;
          default: c = CMD_READ;
        endcase
      end
      r = $urandom_range(1, 100);
      if (r <= 2)
        step = $urandom;
      else if (c != CMD_SAMPLE)
        step = $urandom_range(0, 300);
      else if (r <= 2 + long_pct)
        step = $urandom_range(1000, 2600);
      else
        step = $urandom_range(0, 2 * interval_cfg + 2);
      clock_ms = clock_ms + step;
      idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
      send_beat(c, clock_ms, pick_pulses(), idx);
    end
    item_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_SPARE, $urandom);
    set_regs(INTERVAL_RST, 32'd500, 1'b1);

    // directed: early folding, saturation, window clamp, reads, resets, wrap
    put(CMD_SAMPLE,    32'd0,        16'd0,     8'd0);
    put(CMD_SAMPLE,    32'd150,      16'd5,     8'd0);
    put(CMD_SAMPLE,    32'd200,      16'h7FFF,  8'd0);
    put(CMD_SAMPLE,    32'd220,      16'd100,   8'd0);
    put(CMD_SAMPLE,    32'd300,      16'hFFFF,  8'd0);
    put(CMD_SAMPLE,    32'd400,      16'h7FFF,  8'd0);
    put(CMD_SAMPLE,    32'd500,      16'h7FFF,  8'd0);
    put(CMD_SAMPLE,    32'd1300,     16'd0,     8'd0);
    put(CMD_SAMPLE,    32'd2400,     16'd0,     8'd0);
    put(CMD_READ,      32'd2400,     16'h8000,  8'd0);
    put(CMD_READ,      32'd2410,     16'd7,     8'd1);
    put(CMD_READ,      32'd2420,     16'd0,     8'd2);
    put(CMD_READ,      32'd2430,     16'd0,     8'hFF);
    put(CMD_IDLE_RST,  32'd2500,     16'd1000,  8'd0);
    put(CMD_SAMPLE,    32'd2650,     16'd0,     8'd0);
    put(CMD_STATS_RST, 32'd2700,     16'd3,     8'd0);
    put(CMD_READ,      32'd2710,     16'd0,     8'd0);
    put(CMD_SAMPLE,    32'hFFFF_FFA0, 16'd0,    8'd0);
    put(CMD_SAMPLE,    32'h0000_0040, 16'd0,    8'd0);
    put(CMD_SAMPLE,    32'hC000_0040, 16'd0,    8'd0);
    put(CMD_SAMPLE,    32'h8000_0040, 16'd0,    8'd0);
    put(CMD_READ,      32'h8000_0050, 16'h7FFF, 8'd0);
    put(CMD_SAMPLE,    32'h8000_0100, 16'h7FFF, 8'd0);
    put(CMD_STATS_RST, 32'h8000_0200, 16'hFFFF, 8'hAA);
    item_valid <= 1'b0;
    settle();

    // free-running, statistics resets allowed
    set_regs(16'd100, 32'd5000, 1'b1);
    random_beats(300, 75, 30, 1'b1);
    settle();

    // every sample taken, no statistics reset: ring fills and wraps
    set_regs(16'd0, 32'hFFFF_FFFF, 1'b1);
    send_idle_pct = 54;
    random_beats(400, 88, 90, 1'b0);
    settle();

    // widest interval, log off, receiver holds off for a long stretch
    set_regs(16'hFFFF, 32'd0, 1'b0);
    send_idle_pct = 0;
    stall_pct    <= 54;
    hold_req     <= 1'b1;
    random_beats(300, 75, 30, 1'b1);
    settle();

    set_regs(16'($urandom_range(1, 2000)), $urandom_range(0, 20000), 1'b1);
    send_idle_pct = 23;
    stall_pct    <= 23;
    random_beats(330, 75, 40, 1'b1);
    settle();

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/bait_pkg.sv
hdl/bus_activity_idle_tracker.sv
tb/bait_activity_checker.sv
tb/tb.sv
